// ===== src/lthsv_pkg.sv =====
package lthsv_pkg;

    localparam int unsigned GREY_RAMP_SIZE = 256;
    localparam int unsigned IDX_W          = 10;
    localparam int unsigned COL_W          = 8;
    localparam int unsigned FACTOR_W       = 9;
    localparam logic [8:0]  FACTOR_RESET   = 9'd200;
    localparam int unsigned HUE_W          = 11;
    localparam int unsigned DVD_W          = 19;
    localparam int unsigned DVS_W          = 11;
    localparam int unsigned QUO_W          = 8;
    localparam int unsigned DIV_STEPS      = 8;
    localparam int unsigned FIFO_DEPTH     = 4;
    localparam int unsigned FIFO_AW        = 2;
    localparam int unsigned FIFO_CW        = 3;
    localparam int unsigned PROD_W         = 19;

    // Register byte-address selector
    localparam logic REG_LIGHT_FACTOR = 1'b0;

    typedef struct packed {
        logic              grey;
        logic [IDX_W-1:0]  idx;
        logic [COL_W-1:0]  mx;
        logic [COL_W-1:0]  d;
        logic [HUE_W-1:0]  n;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Hue sector from 6*H, H in 0..254.
    function automatic logic [2:0] hue_sector(input logic [HUE_W-1:0] six_h);
        logic [2:0] sec;
        if (six_h >= 11'd1275) begin
            sec = 3'd5;
        end else if (six_h >= 11'd1020) begin
            sec = 3'd4;
        end else if (six_h >= 11'd765) begin
            sec = 3'd3;
        end else if (six_h >= 11'd510) begin
            sec = 3'd2;
        end else if (six_h >= 11'd255) begin
            sec = 3'd1;
        end else begin
            sec = 3'd0;
        end
        return sec;
    endfunction

endpackage

// ===== src/lthsv_front.sv =====
module lthsv_front (
    input  logic [lthsv_pkg::IDX_W-1:0] light_index,
    input  logic [lthsv_pkg::COL_W-1:0] red,
    input  logic [lthsv_pkg::COL_W-1:0] green,
    input  logic [lthsv_pkg::COL_W-1:0] blue,
    output lthsv_pkg::entry_t           entry
);

    // Classify the entry and reduce the colour to max, spread and hue numerator.
    always_comb begin
        logic [7:0]  mx;
        logic [7:0]  mn;
        logic [7:0]  d;
        logic [10:0] d2;
        logic [10:0] d4;
        logic [10:0] d6;
        logic [12:0] nn;
        mx = red;
        if (green > mx) begin
            mx = green;
        end
        if (blue > mx) begin
            mx = blue;
        end
        mn = red;
        if (green < mn) begin
            mn = green;
        end
        if (blue < mn) begin
            mn = blue;
        end
        d  = mx - mn;
        d2 = 11'({d, 1'b0});
        d4 = 11'({d, 2'b0});
        d6 = d4 + d2;
        if (red == mx) begin
            nn = 13'(green) - 13'(blue);
            if (nn[12]) begin
                nn = nn + 13'(d6);
            end
        end else if (green == mx) begin
            nn = 13'(blue) - 13'(red) + 13'(d2);
        end else begin
            nn = 13'(red) - 13'(green) + 13'(d4);
        end
        entry.grey = ({1'b0, light_index} < 11'(lthsv_pkg::GREY_RAMP_SIZE));
        entry.idx  = light_index;
        entry.mx   = mx;
        entry.d    = d;
        entry.n    = nn[10:0];
    end

endmodule

// ===== src/lthsv_fifo.sv =====
module lthsv_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  lthsv_pkg::entry_t      wr_entry,
    input  logic                   pop,
    output lthsv_pkg::entry_t      rd_entry,
    output lthsv_pkg::fifo_stat_t  stat
);

    lthsv_pkg::entry_t                mem_reg [0:lthsv_pkg::FIFO_DEPTH-1];
    logic [lthsv_pkg::FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lthsv_pkg::FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lthsv_pkg::FIFO_CW-1:0]    cnt_reg, cnt_next;

    function automatic logic [lthsv_pkg::FIFO_CW-1:0] FIFO_CW_ONE(input logic b);
        return {{(lthsv_pkg::FIFO_CW-1){1'b0}}, b};
    endfunction

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CW_ONE(push) - FIFO_CW_ONE(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry   = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == lthsv_pkg::FIFO_CW'(lthsv_pkg::FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// ===== src/lthsv_div.sv =====
module lthsv_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [lthsv_pkg::DVD_W-1:0] dividend,
    input  logic [lthsv_pkg::DVS_W-1:0] divisor,
    output logic [lthsv_pkg::QUO_W-1:0] quotient
);

    // One restoring step per stage; the quotient is known to fit in QUO_W bits.
    logic [lthsv_pkg::DVD_W-1:0] rem_reg [0:lthsv_pkg::DIV_STEPS];
    logic [lthsv_pkg::DVS_W-1:0] dvs_reg [0:lthsv_pkg::DIV_STEPS];
    logic [lthsv_pkg::QUO_W-1:0] quo_reg [0:lthsv_pkg::DIV_STEPS];
    logic [lthsv_pkg::DVD_W-1:0] sh      [0:lthsv_pkg::DIV_STEPS-1];
    logic                        ge      [0:lthsv_pkg::DIV_STEPS-1];

    always_comb begin
        for (int k = 0; k < lthsv_pkg::DIV_STEPS; k++) begin
            sh[k] = lthsv_pkg::DVD_W'(dvs_reg[k]) << (lthsv_pkg::DIV_STEPS - 1 - k);
            ge[k] = (rem_reg[k] >= sh[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= dividend;
            dvs_reg[0] <= divisor;
            quo_reg[0] <= '0;
            for (int k = 0; k < lthsv_pkg::DIV_STEPS; k++) begin
                rem_reg[k+1] <= ge[k] ? rem_reg[k] - sh[k] : rem_reg[k];
                dvs_reg[k+1] <= dvs_reg[k];
                quo_reg[k+1] <= quo_reg[k]
                              | (ge[k] ? lthsv_pkg::QUO_W'(1) << (lthsv_pkg::DIV_STEPS - 1 - k)
                                       : '0);
            end
        end
    end

    assign quotient = quo_reg[lthsv_pkg::DIV_STEPS];

endmodule

// ===== src/lthsv_back.sv =====
module lthsv_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lthsv_pkg::FACTOR_W-1:0] factor,
    input  lthsv_pkg::entry_t              head,
    input  logic                           head_valid,
    output logic                           pop,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic [lthsv_pkg::COL_W-1:0]    m_out_red,
    output logic [lthsv_pkg::COL_W-1:0]    m_out_green,
    output logic [lthsv_pkg::COL_W-1:0]    m_out_blue
);

    localparam int unsigned NS = lthsv_pkg::DIV_STEPS;

    logic        en;
    logic        flat_h;
    logic [9:0]  vsrc;
    logic [18:0] vprod_h;
    logic [18:0] dvd_s, dvd_h;
    logic [10:0] dvs_s, dvs_h;
    logic [7:0]  s_q, h_q;
    logic [7:0]  v_scaled;
    logic [30:0] vmul;

    logic [NS:0] vld_reg;
    logic        flat_reg [0:NS];
    logic [7:0]  v_reg    [1:NS];
    logic [18:0] vprod_reg;

    // post-divide stages
    logic        p1_vld_reg, p2_vld_reg, p3_vld_reg, m_valid_reg;
    logic        p1_flat_reg, p2_flat_reg, p3_flat_reg;
    logic [7:0]  p1_v_reg, p2_v_reg, p3_v_reg;
    logic [2:0]  p1_sec_reg, p2_sec_reg, p3_sec_reg;
    logic [15:0] p1_sf_reg, p1_sg_reg, p1_pp_reg;
    logic [7:0]  p2_p_reg, p3_p_reg;
    logic [23:0] p2_av_reg, p2_bv_reg;
    logic [16:0] p3_ya_reg, p3_yb_reg;
    logic [7:0]  r_reg, g_reg, b_reg;

    logic [7:0]  h2, f;
    logic [10:0] six_h;
    logic [2:0]  sec;
    logic [16:0] psum;
    logic [48:0] ya_m, yb_m;
    logic [33:0] q_m, t_m;
    logic [7:0]  q, t;
    logic [7:0]  r_next, g_next, b_next;

    assign en  = !m_valid_reg || m_ready;
    assign pop = en && head_valid;

    // Head of the queue: set up both divisions and the value product.
    always_comb begin
        flat_h  = head.grey || (head.d == '0);
        vsrc    = head.grey ? head.idx : {2'b0, head.mx};
        vprod_h = 19'(vsrc) * 19'(factor);
        dvd_s   = 19'(16'({head.d, 8'b0}) - 16'(head.d));
        dvd_h   = 19'({head.n, 8'b0}) - 19'(head.n);
        dvs_s   = 11'(head.mx);
        dvs_h   = 11'({head.d, 2'b0}) + 11'({head.d, 1'b0});
    end

    lthsv_div u_div_sat (
        .aclk     (aclk),
        .en       (en),
        .dividend (dvd_s),
        .divisor  (dvs_s),
        .quotient (s_q)
    );

    lthsv_div u_div_hue (
        .aclk     (aclk),
        .en       (en),
        .dividend (dvd_h),
        .divisor  (dvs_h),
        .quotient (h_q)
    );

    // floor(x/100) clamped to 255, as floor((x>>2)/25) by reciprocal
    always_comb begin
        vmul = 31'(vprod_reg[14:2]) * 31'(18'd167773);
        if (vprod_reg >= 19'd25600) begin
            v_scaled = 8'd255;
        end else begin
            v_scaled = vmul[29:22];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NS-1:0], head_valid};
            p1_vld_reg  <= vld_reg[NS];
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            m_valid_reg <= p3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flat_reg[0] <= flat_h;
            vprod_reg   <= vprod_h;
            flat_reg[1] <= flat_reg[0];
            v_reg[1]    <= v_scaled;
            for (int k = 1; k < NS; k++) begin
                flat_reg[k+1] <= flat_reg[k];
                v_reg[k+1]    <= v_reg[k];
            end
        end
    end

    // Sector, fraction and the three 8x8 products.
    always_comb begin
        h2    = (h_q == 8'd255) ? 8'd0 : h_q;
        six_h = 11'({h2, 2'b0}) + 11'({h2, 1'b0});
        sec   = lthsv_pkg::hue_sector(six_h);
        f     = 8'(six_h - 11'(sec) * 11'd255);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_flat_reg <= flat_reg[NS];
            p1_v_reg    <= v_reg[NS];
            p1_sec_reg  <= sec;
            p1_sf_reg   <= 16'(s_q) * 16'(f);
            p1_sg_reg   <= 16'(s_q) * 16'(8'd255 - f);
            p1_pp_reg   <= 16'(8'd255 - s_q) * 16'(v_reg[NS]);
        end
    end

    assign psum = 17'(p1_pp_reg) + 17'(p1_pp_reg[15:8]) + 17'd1;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_flat_reg <= p1_flat_reg;
            p2_v_reg    <= p1_v_reg;
            p2_sec_reg  <= p1_sec_reg;
            p2_p_reg    <= psum[15:8];
            p2_av_reg   <= 24'(16'd65025 - p1_sf_reg) * 24'(p1_v_reg);
            p2_bv_reg   <= 24'(16'd65025 - p1_sg_reg) * 24'(p1_v_reg);
        end
    end

    // First /255 by reciprocal, second in the next stage
    assign ya_m = 49'(p2_av_reg) * 49'(25'd16843010);
    assign yb_m = 49'(p2_bv_reg) * 49'(25'd16843010);

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_flat_reg <= p2_flat_reg;
            p3_v_reg    <= p2_v_reg;
            p3_sec_reg  <= p2_sec_reg;
            p3_p_reg    <= p2_p_reg;
            p3_ya_reg   <= ya_m[48:32];
            p3_yb_reg   <= yb_m[48:32];
        end
    end

    assign q_m = 34'(p3_ya_reg) * 34'(17'd65794);
    assign t_m = 34'(p3_yb_reg) * 34'(17'd65794);
    assign q   = q_m[31:24];
    assign t   = t_m[31:24];

    always_comb begin
        if (p3_flat_reg) begin
            r_next = p3_v_reg;
            g_next = p3_v_reg;
            b_next = p3_v_reg;
        end else begin
            case (p3_sec_reg)
                3'd0: begin
                    r_next = p3_v_reg; g_next = t;        b_next = p3_p_reg;
                end
                3'd1: begin
                    r_next = q;        g_next = p3_v_reg; b_next = p3_p_reg;
                end
                3'd2: begin
                    r_next = p3_p_reg; g_next = p3_v_reg; b_next = t;
                end
                3'd3: begin
                    r_next = p3_p_reg; g_next = q;        b_next = p3_v_reg;
                end
                3'd4: begin
                    r_next = t;        g_next = p3_p_reg; b_next = p3_v_reg;
                end
                default: begin
                    r_next = p3_v_reg; g_next = p3_p_reg; b_next = q;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = r_reg;
    assign m_out_green = g_reg;
    assign m_out_blue  = b_reg;

endmodule

// ===== src/light_table_hsv_brightness_core.sv =====
// Throughput: one transaction per cycle unless m_ready stalls the output, set by the
// 8-stage pipelined dividers for saturation and hue and the multiplier stages behind them.
// Reset: aresetn synchronous, active low; clears the queue and all valid flags,
// light_factor returns to 200.
module light_table_hsv_brightness_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_light_index,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [lthsv_pkg::FACTOR_W-1:0] factor_reg;
    lthsv_pkg::entry_t              front_entry;
    lthsv_pkg::entry_t              head_entry;
    lthsv_pkg::fifo_stat_t          fifo_stat;
    logic                           push;
    logic                           pop;

    // Configuration: single register at byte address 0; pready is tied high.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= lthsv_pkg::FACTOR_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == lthsv_pkg::REG_LIGHT_FACTOR)) begin
            factor_reg <= pwdata[lthsv_pkg::FACTOR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == lthsv_pkg::REG_LIGHT_FACTOR) ? 32'(factor_reg) : '0;

    // Front: classify each transaction and queue it while there is room.
    lthsv_front u_front (
        .light_index (s_light_index),
        .red         (s_red),
        .green       (s_green),
        .blue        (s_blue),
        .entry       (front_entry)
    );

    assign s_ready = !fifo_stat.full;
    assign push    = s_valid && s_ready;

    // Short queue decouples acceptance from the back pipeline stalls.
    lthsv_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (front_entry),
        .pop      (pop),
        .rd_entry (head_entry),
        .stat     (fifo_stat)
    );

    // Back: pipelined HSV round trip; advance whenever the output register is free.
    lthsv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .factor      (factor_reg),
        .head        (head_entry),
        .head_valid  (!fifo_stat.empty),
        .pop         (pop),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue)
    );

endmodule

// ===== src/lthsv_checker.sv =====
module lthsv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_red,
    input logic [7:0]  m_out_green,
    input logic [7:0]  m_out_blue,
    input logic        pready
);

    // Hold a stalled result with its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red)
                                && $stable(m_out_green) && $stable(m_out_blue))
        else $error("stalled result changed");

    // Drop all results on reset.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Queue empty after reset, so input is taken straight away.
    a_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind light_table_hsv_brightness_core lthsv_checker u_lthsv_checker (.*);
